>>> src/dvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvc_pkg
// Shared item types, request codes, controller states and the command and
// status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package dvc_pkg;

    // Request codes carried in the req_type field.
    localparam logic REQ_COUNT = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // One input item.
    typedef struct packed {
        logic               req_type;
        logic signed [31:0] sample_value;
        logic        [5:0]  read_index;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic        [5:0]  entry_index;
        logic signed [31:0] entry_value;
        logic        [15:0] entry_count;
        logic               entry_valid;
        logic               new_entry;
        logic               table_full;
        logic        [6:0]  distinct_total;
    } t_out_item;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_UPDATE,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // accept the input item
        logic issue;     // issue the next search read
        logic compare;   // compare returned entry against the sample
        logic update;    // write the table and build a count result
        logic read_cap;  // build a read result from the returned entry
        logic load_out;  // move the result into the output register
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_is_read;  // offered item is a read request
        logic used_zero;   // table holds no entries
        logic match;       // returned entry holds the sample
        logic last_miss;   // last used entry returned without a match
        logic out_free;    // output register can take a result
    } t_dp_status;

endpackage

>>> src/dvc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dvc_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/dvc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvc_ctrl
// Controller state machine: accepts one item, steps the table search or the
// entry read, orders the table update and hands the result to the output.
// ----------------------------------------------------------------------------
module dvc_ctrl
    import dvc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.in_is_read) begin
                        n_state = S_READ;
                    end else if (i_status.used_zero) begin
                        n_state = S_UPDATE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_status.match || i_status.last_miss) begin
                    n_state = S_UPDATE;
                end
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_UPDATE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.start = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.issue   = 1'b1;
                o_cmd.compare = 1'b1;
            end
            S_READ: begin
                o_cmd.read_cap = 1'b1;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            S_DONE: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

>>> src/dvc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvc_datapath
// Table storage, search address counter, entry compare, count update and
// the result and output registers.
// ----------------------------------------------------------------------------
module dvc_datapath
    import dvc_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctrl_cmd  i_cmd,
    output t_dp_status o_status,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int UW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (UW > 6) ? UW : 6;
    localparam int RW = 32 + COUNT_WIDTH;

    // Control registers.
    logic [UW-1:0]          r_used;
    logic [UW-1:0]          n_used;
    logic [UW-1:0]          r_addr;
    logic                   r_pend;
    logic                   r_hit;
    logic                   r_rd_ok;
    logic                   r_out_valid;

    // Payload registers.
    logic [IW-1:0]          r_pend_addr;
    logic [31:0]            r_sample;
    logic [IW-1:0]          r_hit_idx;
    logic [COUNT_WIDTH-1:0] r_hit_cnt;
    logic [5:0]             r_rd_idx;
    t_out_item              r_res;
    t_out_item              n_res;
    t_out_item              r_out_item;

    logic                   in_range;
    logic                   issue_eff;
    logic                   rd_en;
    logic [IW-1:0]          rd_addr;
    logic [RW-1:0]          rd_data;
    logic [31:0]            rd_value;
    logic [COUNT_WIDTH-1:0] rd_cnt;
    logic                   value_eq;
    logic                   match_now;
    logic                   last_miss;
    logic                   room;
    logic [COUNT_WIDTH-1:0] hit_new_cnt;
    logic                   wr_en;
    logic [IW-1:0]          wr_addr;
    logic [RW-1:0]          wr_data;
    logic                   out_free;

    // Read request range check against the entries in use.
    assign in_range = XW'(i_in_item.read_index) < XW'(r_used);

    // Search reads run only over the entries in use.
    assign issue_eff = i_cmd.issue && (r_addr < r_used);
    assign rd_en     = issue_eff ||
                       (i_cmd.start && (i_in_item.req_type == REQ_READ) && in_range);
    assign rd_addr   = i_cmd.start ? IW'(i_in_item.read_index) : r_addr[IW-1:0];

    assign rd_value = rd_data[RW-1:COUNT_WIDTH];
    assign rd_cnt   = rd_data[COUNT_WIDTH-1:0];

    // Compare of the entry returned by the previous search read.
    assign value_eq  = (rd_value == r_sample);
    assign match_now = r_pend && value_eq;
    assign last_miss = r_pend && !value_eq &&
                       ((UW'(r_pend_addr) + UW'(1)) == r_used);

    // Table update: saturating increment on a hit, fresh entry on a miss.
    assign room        = r_used < UW'(TABLE_DEPTH);
    assign hit_new_cnt = (r_hit_cnt == {COUNT_WIDTH{1'b1}}) ?
                         r_hit_cnt : r_hit_cnt + COUNT_WIDTH'(1);
    assign wr_en       = i_cmd.update && (r_hit || room);
    assign wr_addr     = r_hit ? r_hit_idx : r_used[IW-1:0];
    assign wr_data     = {r_sample, (r_hit ? hit_new_cnt : COUNT_WIDTH'(1))};

    always_comb begin
        n_used = r_used;
        if (i_cmd.update && !r_hit && room) begin
            n_used = r_used + UW'(1);
        end
    end

    dvc_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Result item for the finished request.
    always_comb begin
        n_res = r_res;
        if (i_cmd.read_cap) begin
            n_res.entry_index    = r_rd_idx;
            n_res.entry_value    = r_rd_ok ? rd_value : 32'd0;
            n_res.entry_count    = r_rd_ok ? 16'(rd_cnt) : 16'd0;
            n_res.entry_valid    = r_rd_ok;
            n_res.new_entry      = 1'b0;
            n_res.table_full     = 1'b0;
            n_res.distinct_total = 7'(r_used);
        end else if (i_cmd.update) begin
            n_res.entry_value    = r_sample;
            n_res.distinct_total = 7'(n_used);
            if (r_hit) begin
                n_res.entry_index = 6'(r_hit_idx);
                n_res.entry_count = 16'(hit_new_cnt);
                n_res.entry_valid = 1'b1;
                n_res.new_entry   = 1'b0;
                n_res.table_full  = 1'b0;
            end else if (room) begin
                n_res.entry_index = 6'(r_used);
                n_res.entry_count = 16'd1;
                n_res.entry_valid = 1'b1;
                n_res.new_entry   = 1'b1;
                n_res.table_full  = 1'b0;
            end else begin
                n_res.entry_index = 6'd0;
                n_res.entry_count = 16'd0;
                n_res.entry_valid = 1'b0;
                n_res.new_entry   = 1'b0;
                n_res.table_full  = 1'b1;
            end
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_used <= n_used;
            r_pend <= issue_eff;
            if (i_cmd.start) begin
                r_addr  <= '0;
                r_hit   <= 1'b0;
                r_rd_ok <= in_range;
            end else begin
                if (issue_eff) begin
                    r_addr <= r_addr + UW'(1);
                end
                if (i_cmd.compare && match_now) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_sample <= i_in_item.sample_value;
            r_rd_idx <= i_in_item.read_index;
        end
        if (issue_eff) begin
            r_pend_addr <= r_addr[IW-1:0];
        end
        if (i_cmd.compare && match_now) begin
            r_hit_idx <= r_pend_addr;
            r_hit_cnt <= rd_cnt;
        end
        r_res <= n_res;
        if (i_cmd.load_out) begin
            r_out_item <= r_res;
        end
    end

    assign o_status.in_is_read = (i_in_item.req_type == REQ_READ);
    assign o_status.used_zero  = (r_used == '0);
    assign o_status.match      = match_now;
    assign o_status.last_miss  = last_miss;
    assign o_status.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> src/distinct_value_counter_core.sv
`timescale 1ns / 1ps
// Read request: the table is read on acceptance, the result built in S_READ and
// moved to the output register in S_DONE. Count request: the search ends on a
// match or last used entry, one entry per cycle through the single read port.
// A new item is taken once the previous result sits in the output register.
// Reset clears the used-entry count and all control state; table contents are
// not cleared, since only entries below the used count are ever read.
// ----------------------------------------------------------------------------
// distinct_value_counter_core
// Associative frequency counter: counts occurrences of distinct 32-bit values
// in a table and returns single entries on request.
// ----------------------------------------------------------------------------
module distinct_value_counter_core
    import dvc_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // Controller.
    dvc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath.
    dvc_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTHESIS
    // An accepted item keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted again right after an item");

    // A fresh entry always starts valid with a count of one.
    a_new_entry_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.new_entry) |->
        (o_out_item.entry_valid && !o_out_item.table_full &&
         (o_out_item.entry_count == 16'd1)))
        else $error("new entry result is malformed");

    // A dropped value is never reported as counted.
    a_full_not_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.table_full) |->
        (!o_out_item.entry_valid && !o_out_item.new_entry))
        else $error("table full result flagged as counted");

    // The result is only loaded while the output register is free.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out_valid || !i_out_stall))
        else $error("result loaded over a stalled item");
`endif

endmodule
